@@ rtl/bmp565_pkg.sv @@
// Shared types and constants for the BMP byte stream to RGB565 converter.
// Used by the top level; depends on nothing.
package bmp565_pkg;

  // Status codes carried on the final status word.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_FORMAT  = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE    = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_SHORT       = 3'd4;
  localparam logic [2:0] ST_BUFFER      = 3'd5;

  // Result kinds.
  localparam logic RK_PIXEL  = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  // Header layout: positions of the last byte of each checked field.
  localparam logic [31:0] HEADER_BYTES = 32'd54;
  localparam logic [31:0] POS_SIG0     = 32'd0;
  localparam logic [31:0] POS_SIG1     = 32'd1;
  localparam logic [31:0] POS_OFFSET   = 32'd13;
  localparam logic [31:0] POS_INFO     = 32'd17;
  localparam logic [31:0] POS_WIDTH    = 32'd21;
  localparam logic [31:0] POS_HEIGHT   = 32'd25;
  localparam logic [31:0] POS_PLANES   = 32'd27;
  localparam logic [31:0] POS_DEPTH    = 32'd29;
  localparam logic [31:0] POS_COMPR    = 32'd33;

  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4D;
  localparam logic [31:0] MIN_INFO     = 32'd40;
  localparam logic [15:0] DEPTH_16     = 16'd16;
  localparam logic [15:0] DEPTH_24     = 16'd24;
  localparam logic [15:0] DEPTH_32     = 16'd32;
  localparam logic [31:0] COMPR_RGB    = 32'd0;
  localparam logic [31:0] COMPR_FIELDS = 32'd3;

  localparam int          BUF_W        = 22;
  localparam logic [BUF_W-1:0] BUF_RESET = 22'd2097152;

  // One result word as held in the output queue.
  typedef struct packed {
    logic        result_kind;
    logic [15:0] pixel_value;
    logic [19:0] pixel_index;
    logic [2:0]  status_code;
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [5:0]  bits_per_pixel;
    logic        is_last;
  } result_t;

endpackage

@@ rtl/bmp565_if.sv @@
// Valid/ready channel interfaces of the converter: input bytes, results and
// the configuration write channel. Depends on nothing.
interface bmp565_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       last_byte;

  modport source (output valid, output file_byte, output last_byte, input ready);
  modport sink   (input valid, input file_byte, input last_byte, output ready);
endinterface

interface bmp565_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] pixel_value;
  logic [19:0] pixel_index;
  logic [2:0]  status_code;
  logic [10:0] image_width;
  logic [10:0] image_height;
  logic [5:0]  bits_per_pixel;
  logic        is_last;

  modport source (output valid, output result_kind, output pixel_value,
                  output pixel_index, output status_code, output image_width,
                  output image_height, output bits_per_pixel, output is_last,
                  input ready);
  modport sink   (input valid, input result_kind, input pixel_value,
                  input pixel_index, input status_code, input image_width,
                  input image_height, input bits_per_pixel, input is_last,
                  output ready);
endinterface

interface bmp565_cfg_if;
  logic        valid;
  logic        ready;
  logic [21:0] output_buffer_bytes;

  modport source (output valid, output output_buffer_bytes, input ready);
  modport sink   (input valid, input output_buffer_bytes, output ready);
endinterface

@@ rtl/bmp_stream_to_rgb565.sv @@
// BMP byte stream to RGB565 converter, top level.
// Depends on bmp565_pkg and the channel interfaces in bmp565_if.sv.
//
// Usage: the bytes channel takes one word per cycle, a file byte plus a flag
// that marks the last byte of the file. The header is checked as it streams
// by; bytes up to the pixel data offset are skipped, row padding is dropped,
// and each complete pixel leaves on the results channel as an RGB565 word
// with its destination index (rows flipped for bottom-up files). The byte
// flagged last also produces one status word, after any pixel word of that
// byte; the block then starts over on the next byte as a new file.
// The cfg channel writes the destination capacity in bytes; it is always
// ready and is meant to be written between files.
// A result word is queued when its byte is accepted and is offered once
// the words ahead of it have left. Throughput: one byte per cycle while the
// queue has room, set by the counters and field registers; a byte that
// yields two words queues both together. A four-word result queue decouples
// the sides: bytes are taken while it holds two words or fewer, so a stalled
// receiver stops the byte channel after at most four waiting words.
// Reset clears the parse state and the queue and sets the capacity to 2 MiB.
module bmp_stream_to_rgb565 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input logic          clk,
  input logic          rst,
  bmp565_cfg_if.sink   cfg,
  bmp565_in_if.sink    bytes,
  bmp565_out_if.source results
);
  import bmp565_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW  = WW + HW;
  localparam int CW  = (AW + 1 > BUF_W) ? AW + 1 : BUF_W;
  localparam int RBW = WW + 3;
  localparam int FD  = 4;
  localparam int FAW = $clog2(FD);
  localparam int FCW = $clog2(FD + 1);

  // Configuration register.
  logic [BUF_W-1:0] output_buffer_bytes;

  // Parse state.
  logic [31:0]  byte_position, byte_position_next;
  logic [31:0]  field_assembly, field_assembly_next;
  logic [31:0]  pixel_start, pixel_start_next;
  logic [WW-1:0] width_reg, width_reg_next;
  logic [HW-1:0] height_reg, height_reg_next;
  logic         rows_flipped, rows_flipped_next;
  logic [5:0]   depth_reg, depth_reg_next;
  logic [WW-1:0] column_count, column_count_next;
  logic [HW-1:0] row_count, row_count_next;
  logic [RBW-1:0] row_byte_count, row_byte_count_next;
  logic [1:0]   sub_count, sub_count_next;
  logic [23:0]  pixel_gather, pixel_gather_next;
  logic [2:0]   error_latch, error_latch_next;

  // Result queue.
  result_t      fifo_mem [FD];
  logic [FAW-1:0] wr_ptr, wr_ptr_next, wr_ptr_plus, rd_ptr, rd_ptr_next;
  logic [FCW-1:0] count, count_next;

  // Per-byte working signals.
  logic         accept, pop;
  logic [31:0]  f_new, f_abs;
  logic [15:0]  half;
  logic [AW-1:0] area;
  logic         area_too_big;
  logic [2:0]   bpp_bytes;
  logic [RBW-1:0] data_len, stride, rbc_inc;
  logic [HW-1:0] dest_row;
  logic [AW-1:0] dest_index;
  logic [15:0]  pix_value;
  logic         emit;
  logic [2:0]   final_status;
  result_t      pixel_word, status_word, first_word;
  logic         push_first, push_second;

  assign accept = bytes.valid && bytes.ready;
  assign pop    = results.valid && results.ready;
  assign bytes.ready = (count <= FCW'(FD - 2));
  assign cfg.ready   = 1'b1;

  // Header field decode from the assembled little-endian word.
  assign f_new = {bytes.file_byte, field_assembly[31:8]};
  assign half  = f_new[31:16];
  assign f_abs = f_new[31] ? (32'd0 - f_new) : f_new;
  assign area  = AW'(width_reg) * AW'(height_reg);
  assign area_too_big = CW'({area, 1'b0}) > CW'(output_buffer_bytes);

  // Row geometry from the parsed width and depth.
  assign bpp_bytes = depth_reg[5:3];
  always_comb begin
    unique case (bpp_bytes)
      3'd2:    data_len = RBW'({width_reg, 1'b0});
      3'd3:    data_len = RBW'(width_reg) + RBW'({width_reg, 1'b0});
      3'd4:    data_len = RBW'({width_reg, 2'b00});
      default: data_len = '0;
    endcase
  end
  assign stride  = (data_len + RBW'(3)) & ~RBW'(3);
  assign rbc_inc = row_byte_count + RBW'(1);

  // Destination index with the row flipped for bottom-up files.
  assign dest_row   = rows_flipped ? (height_reg - HW'(1) - row_count) : row_count;
  assign dest_index = AW'(dest_row) * AW'(width_reg) + AW'(column_count);

  // Next-state logic for one accepted byte.
  always_comb begin
    byte_position_next     = byte_position;
    field_assembly_next    = field_assembly;
    pixel_start_next       = pixel_start;
    width_reg_next         = width_reg;
    height_reg_next        = height_reg;
    rows_flipped_next      = rows_flipped;
    depth_reg_next         = depth_reg;
    column_count_next      = column_count;
    row_count_next         = row_count;
    row_byte_count_next    = row_byte_count;
    sub_count_next         = sub_count;
    pixel_gather_next      = pixel_gather;
    error_latch_next       = error_latch;
    emit                   = 1'b0;
    pix_value              = '0;
    final_status           = ST_OK;

    if (accept) begin
      field_assembly_next = f_new;
      if (byte_position != 32'hFFFF_FFFF) begin
        byte_position_next = byte_position + 32'd1;
      end

      if (error_latch == ST_OK) begin
        if (byte_position < HEADER_BYTES) begin
          // Header checks, each on the last byte of its field.
          unique case (byte_position)
            POS_SIG0: begin
              if (bytes.file_byte != SIG_B) error_latch_next = ST_BAD_FORMAT;
            end
            POS_SIG1: begin
              if (bytes.file_byte != SIG_M) error_latch_next = ST_BAD_FORMAT;
            end
            POS_OFFSET: begin
              pixel_start_next = f_new;
            end
            POS_INFO: begin
              if (f_new < MIN_INFO) error_latch_next = ST_BAD_FORMAT;
            end
            POS_WIDTH: begin
              if (f_new[31] || f_new == 32'd0 || f_new > 32'(MAX_WIDTH)) begin
                error_latch_next = ST_BAD_SIZE;
              end else begin
                width_reg_next = WW'(f_new);
              end
            end
            POS_HEIGHT: begin
              if (f_new == 32'd0 || f_abs > 32'(MAX_HEIGHT)) begin
                error_latch_next = ST_BAD_SIZE;
              end else begin
                height_reg_next   = HW'(f_abs);
                rows_flipped_next = !f_new[31];
              end
            end
            POS_PLANES: begin
              if (half != 16'd1) error_latch_next = ST_BAD_FORMAT;
            end
            POS_DEPTH: begin
              if (half != DEPTH_16 && half != DEPTH_24 && half != DEPTH_32) begin
                error_latch_next = ST_UNSUPPORTED;
              end else begin
                depth_reg_next = 6'(half);
              end
            end
            POS_COMPR: begin
              priority if (f_new != COMPR_RGB && f_new != COMPR_FIELDS) begin
                error_latch_next = ST_UNSUPPORTED;
              end else if (area_too_big) begin
                error_latch_next = ST_BUFFER;
              end else if (pixel_start < HEADER_BYTES) begin
                error_latch_next = ST_BAD_FORMAT;
              end else begin
                error_latch_next = ST_OK;
              end
            end
            default: begin
            end
          endcase
        end else if (byte_position >= pixel_start &&
                     row_count < height_reg && bpp_bytes != 3'd0) begin
          // Pixel data: gather bytes of a pixel, then skip row padding.
          if (row_byte_count < data_len) begin
            unique case (sub_count)
              2'd0: pixel_gather_next = {16'd0, bytes.file_byte};
              2'd1: pixel_gather_next = {pixel_gather[23:16], bytes.file_byte,
                                         pixel_gather[7:0]};
              2'd2: pixel_gather_next = {bytes.file_byte, pixel_gather[15:0]};
              default: pixel_gather_next = pixel_gather;
            endcase
            if (sub_count == 2'(bpp_bytes - 3'd1)) begin
              emit              = 1'b1;
              sub_count_next    = 2'd0;
              column_count_next = column_count + WW'(1);
              if (depth_reg == 6'(DEPTH_16)) begin
                pix_value = pixel_gather_next[15:0];
              end else begin
                pix_value = {pixel_gather_next[23:19], pixel_gather_next[15:10],
                             pixel_gather_next[7:3]};
              end
            end else begin
              sub_count_next = sub_count + 2'd1;
            end
          end
          row_byte_count_next = rbc_inc;
          if (rbc_inc >= stride) begin
            row_byte_count_next = '0;
            column_count_next   = '0;
            sub_count_next      = 2'd0;
            row_count_next      = row_count + HW'(1);
          end
        end
      end

      // Final status on the last byte, then back to the start of a file.
      if (bytes.last_byte) begin
        priority if (byte_position < HEADER_BYTES - 32'd1) begin
          final_status = ST_BAD_FORMAT;
        end else if (error_latch_next == ST_OK && row_count_next < height_reg_next) begin
          final_status = ST_SHORT;
        end else begin
          final_status = error_latch_next;
        end
        byte_position_next     = '0;
        field_assembly_next    = '0;
        pixel_start_next       = '0;
        width_reg_next         = '0;
        height_reg_next        = '0;
        rows_flipped_next      = 1'b0;
        depth_reg_next         = '0;
        column_count_next      = '0;
        row_count_next         = '0;
        row_byte_count_next    = '0;
        sub_count_next         = 2'd0;
        pixel_gather_next      = '0;
        error_latch_next       = ST_OK;
      end
    end
  end

  // Result words for this byte.
  always_comb begin
    pixel_word              = '0;
    pixel_word.result_kind  = RK_PIXEL;
    pixel_word.pixel_value  = pix_value;
    pixel_word.pixel_index  = 20'(dest_index);
    pixel_word.is_last      = !bytes.last_byte;

    status_word             = '0;
    status_word.result_kind = RK_STATUS;
    status_word.status_code = final_status;
    status_word.is_last     = 1'b1;
    if (final_status == ST_OK) begin
      status_word.image_width    = 11'(width_reg);
      status_word.image_height   = 11'(height_reg);
      status_word.bits_per_pixel = depth_reg;
    end
  end

  assign push_first  = accept && (emit || bytes.last_byte);
  assign push_second = accept && emit && bytes.last_byte;
  assign first_word  = emit ? pixel_word : status_word;
  assign wr_ptr_plus = wr_ptr + FAW'(1);

  // Queue pointer and fill count updates.
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push_first) begin
      wr_ptr_next = push_second ? (wr_ptr + FAW'(2)) : wr_ptr_plus;
    end
    if (pop) begin
      rd_ptr_next = rd_ptr + FAW'(1);
    end
    count_next = count + FCW'(push_first) + FCW'(push_second) - FCW'(pop);
  end

  // Control and parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_buffer_bytes <= BUF_RESET;
      byte_position       <= '0;
      field_assembly      <= '0;
      pixel_start         <= '0;
      width_reg           <= '0;
      height_reg          <= '0;
      rows_flipped        <= 1'b0;
      depth_reg           <= '0;
      column_count        <= '0;
      row_count           <= '0;
      row_byte_count      <= '0;
      sub_count           <= 2'd0;
      pixel_gather        <= '0;
      error_latch         <= ST_OK;
      wr_ptr              <= '0;
      rd_ptr              <= '0;
      count               <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        output_buffer_bytes <= cfg.output_buffer_bytes;
      end
      byte_position     <= byte_position_next;
      field_assembly    <= field_assembly_next;
      pixel_start       <= pixel_start_next;
      width_reg         <= width_reg_next;
      height_reg        <= height_reg_next;
      rows_flipped      <= rows_flipped_next;
      depth_reg         <= depth_reg_next;
      column_count      <= column_count_next;
      row_count         <= row_count_next;
      row_byte_count    <= row_byte_count_next;
      sub_count         <= sub_count_next;
      pixel_gather      <= pixel_gather_next;
      error_latch       <= error_latch_next;
      wr_ptr            <= wr_ptr_next;
      rd_ptr            <= rd_ptr_next;
      count             <= count_next;
    end
  end

  // Queue storage; entries hold payload only.
  always_ff @(posedge clk) begin
    if (push_first) begin
      fifo_mem[wr_ptr] <= first_word;
    end
    if (push_second) begin
      fifo_mem[wr_ptr_plus] <= status_word;
    end
  end

  // Head of the queue drives the results channel.
  assign results.valid          = (count != '0);
  assign results.result_kind    = fifo_mem[rd_ptr].result_kind;
  assign results.pixel_value    = fifo_mem[rd_ptr].pixel_value;
  assign results.pixel_index    = fifo_mem[rd_ptr].pixel_index;
  assign results.status_code    = fifo_mem[rd_ptr].status_code;
  assign results.image_width    = fifo_mem[rd_ptr].image_width;
  assign results.image_height   = fifo_mem[rd_ptr].image_height;
  assign results.bits_per_pixel = fifo_mem[rd_ptr].bits_per_pixel;
  assign results.is_last        = fifo_mem[rd_ptr].is_last;

  // The queue never holds more words than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FCW'(FD))
    else $error("result queue overflow");

  // The last byte of a file always leaves the parser at the start of a file.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && bytes.last_byte) |=>
      (byte_position == 32'd0 && error_latch == ST_OK && row_count == '0))
    else $error("parse state not cleared after last byte");

  // A latched error holds until the file ends.
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_latch != ST_OK && !(accept && bytes.last_byte)) |=>
      (error_latch == $past(error_latch)))
    else $error("latched error changed inside a file");

endmodule
